// ===== rtl/mlt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlt_pkg
// shared widths, coefficients, types and the divider step for the
// masked luminosity transfer pipeline
// ----------------------------------------------------------------------------
package mlt_pkg;

    // channel layout
    localparam int CHAN_W   = 8;
    localparam int NUM_CH   = 3;
    localparam int CH_BLUE  = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_RED   = 2;
    localparam int IN_W     = 2 * NUM_CH * CHAN_W;
    localparam int OUT_W    = NUM_CH * CHAN_W;

    // pipeline shape
    localparam int NUM_STAGES = 8;
    localparam int DIV_STAGES = 4;
    localparam int DIV_BITS   = 2;

    // fog luma, floor((30r + 59g + 11b) / 100) via reciprocal multiply
    localparam int FOG_WR    = 30;
    localparam int FOG_WG    = 59;
    localparam int FOG_WB    = 11;
    localparam int FOG_RECIP = 5243;
    localparam int FOG_SHIFT = 19;

    // original luma, (4899r + 9617g + 1868b + 8192) >> 14
    localparam int ORIG_WR    = 4899;
    localparam int ORIG_WG    = 9617;
    localparam int ORIG_WB    = 1868;
    localparam int LUMA_RND   = 8192;
    localparam int LUMA_SHIFT = 14;

    // internal widths
    localparam int SUM_W   = 10;
    localparam int FOGX_W  = 15;
    localparam int ORIGY_W = 22;
    localparam int PROD_W  = 28;
    localparam int CL_W    = 2 * CHAN_W;
    localparam int NUM_W   = CL_W + 1;
    localparam int DIV_W   = CHAN_W + 1;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef chan_t [NUM_CH-1:0] pix_t;
    typedef logic [NUM_W-1:0] num_t;

    // one restoring division step: {quotient bit, new remainder}
    function automatic logic [NUM_W:0] div_step(input num_t rem, input num_t dsh);
        logic ge;
        ge = (rem >= dsh);
        return {ge, ge ? num_t'(rem - dsh) : rem};
    endfunction

endpackage

// ===== rtl/masked_luminosity_transfer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_luminosity_transfer
// rescales a fog layer pixel so its luma follows the original pixel, when the
// fog pixel's channel average lies above a programmable threshold
// ----------------------------------------------------------------------------
//  channel   direction  signals                        content
//  s_*       in         s_tvalid s_tready s_tdata      fog b,g,r then orig b,g,r
//  m_*       out        m_tvalid m_tready m_tdata      out b,g,r
//                       m_tuser                        overlay_applied
//  cfg_*     in         cfg_we cfg_wdata               mask_threshold
//
//  eight register stages, one request per clock while m_tready does not stall the output
//  each stage holds its own valid bit and takes new data when it is empty or
//  the next stage moves, so bubbles squeeze out and a stall loses nothing
//  the quotient comes from a two-bit-per-stage restoring divider (four stages)
//  reset clears all valid bits and sets the threshold to zero
// ----------------------------------------------------------------------------
module masked_luminosity_transfer (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [mlt_pkg::CHAN_W-1:0] cfg_wdata,  // mask_threshold
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // fog_blue, fog_green, fog_red, orig_blue, orig_green, orig_red
    input  logic [mlt_pkg::IN_W-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // out_blue, out_green, out_red
    output logic [mlt_pkg::OUT_W-1:0]  m_tdata,
    // overlay_applied
    output logic [0:0]                 m_tuser
);
    import mlt_pkg::*;

    // control state
    chan_t                   thresh_reg;
    logic [NUM_STAGES-1:0]   valid_reg, valid_next;
    logic [NUM_STAGES:0]     rdy;

    // stage 0: weighted sums and mask decision
    logic [FOGX_W-1:0]       fogx0_reg, fogx0_next;
    chan_t                   luma0_reg, luma0_next;
    logic                    apply0_reg, apply0_next;
    pix_t                    fog0_reg, fog0_next;

    // stage 1: fog luma divisor and channel by luma products
    chan_t                   d1_reg, d1_next;
    logic [NUM_CH-1:0][CL_W-1:0] cl1_reg, cl1_next;
    logic                    apply1_reg;
    pix_t                    fog1_reg;

    // stages 2 to 6: divider, index 0 sets up numerators, 1..4 take quotient bits
    num_t [NUM_CH-1:0]       rem_reg  [DIV_STAGES+1];
    num_t [NUM_CH-1:0]       rem_next [DIV_STAGES+1];
    pix_t                    q_reg    [DIV_STAGES+1];
    pix_t                    q_next   [DIV_STAGES+1];
    logic [NUM_CH-1:0]       sat_reg  [DIV_STAGES+1];
    logic [NUM_CH-1:0]       sat_next;
    logic [DIV_W-1:0]        dv_reg   [DIV_STAGES+1];
    logic [DIV_W-1:0]        dv_next;
    logic                    applyd_reg [DIV_STAGES+1];
    pix_t                    fogd_reg   [DIV_STAGES+1];

    // stage 7: output register
    pix_t                    out_reg, out_next;
    logic                    user_reg, user_next;

    // ready chain, each stage free when empty or when its successor moves
    always_comb
    begin
        rdy[NUM_STAGES] = m_tready;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
        valid_next[0] = rdy[0] ? s_tvalid : valid_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            valid_next[k] = rdy[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = valid_reg[NUM_STAGES-1];
    assign m_tdata  = {out_reg[CH_RED], out_reg[CH_GREEN], out_reg[CH_BLUE]};
    assign m_tuser  = user_reg;

    // stage 0: average test as sum > 3t + 2, both luma sums
    always_comb
    begin
        logic [SUM_W-1:0]   sum;
        logic [SUM_W-1:0]   lim;
        logic [ORIGY_W-1:0] origy;
        pix_t               orig;
        for (int c = 0; c < NUM_CH; c++)
        begin
            fog0_next[c] = s_tdata[c*CHAN_W +: CHAN_W];
            orig[c]      = s_tdata[(NUM_CH + c)*CHAN_W +: CHAN_W];
        end
        sum = SUM_W'(fog0_next[CH_BLUE]) + SUM_W'(fog0_next[CH_GREEN])
            + SUM_W'(fog0_next[CH_RED]);
        lim = SUM_W'(thresh_reg) + SUM_W'({thresh_reg, 1'b0}) + SUM_W'(2);
        apply0_next = (sum > lim);
        fogx0_next = FOGX_W'(FOG_WR) * FOGX_W'(fog0_next[CH_RED])
                   + FOGX_W'(FOG_WG) * FOGX_W'(fog0_next[CH_GREEN])
                   + FOGX_W'(FOG_WB) * FOGX_W'(fog0_next[CH_BLUE]);
        origy = ORIGY_W'(ORIG_WR) * ORIGY_W'(orig[CH_RED])
              + ORIGY_W'(ORIG_WG) * ORIGY_W'(orig[CH_GREEN])
              + ORIGY_W'(ORIG_WB) * ORIGY_W'(orig[CH_BLUE])
              + ORIGY_W'(LUMA_RND);
        luma0_next = origy[LUMA_SHIFT +: CHAN_W];
    end

    // stage 1: divide by 100 through reciprocal, clamp to at least one
    always_comb
    begin
        logic [PROD_W-1:0] prod;
        chan_t             f;
        prod = PROD_W'(fogx0_reg) * PROD_W'(FOG_RECIP);
        f    = prod[FOG_SHIFT +: CHAN_W];
        d1_next = (f == '0) ? CHAN_W'(1) : f;
        for (int c = 0; c < NUM_CH; c++)
        begin
            cl1_next[c] = CL_W'(fog0_reg[c]) * CL_W'(luma0_reg);
        end
    end

    // stage 2: numerator 2cl + d over divisor 2d, quotient of 256 or more saturates
    // stages 3 to 6: two restoring steps each, quotient msb first
    always_comb
    begin
        logic [NUM_W:0] st;
        num_t           r;
        chan_t          q;
        int             b;
        dv_next = {d1_reg, 1'b0};
        for (int c = 0; c < NUM_CH; c++)
        begin
            rem_next[0][c] = {cl1_reg[c], 1'b0} + NUM_W'(d1_reg);
            q_next[0][c]   = '0;
            sat_next[c]    = (rem_next[0][c] >= {d1_reg, {DIV_W{1'b0}}});
        end
        for (int j = 1; j <= DIV_STAGES; j++)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                r = rem_reg[j-1][c];
                q = q_reg[j-1][c];
                for (int s = 0; s < DIV_BITS; s++)
                begin
                    b  = (DIV_STAGES - j) * DIV_BITS + (DIV_BITS - 1 - s);
                    st = div_step(r, NUM_W'(dv_reg[j-1]) << b);
                    q[b] = st[NUM_W];
                    r    = st[NUM_W-1:0];
                end
                rem_next[j][c] = r;
                q_next[j][c]   = q;
            end
        end
    end

    // stage 7: pick scaled, saturated or passed-through channels
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (!applyd_reg[DIV_STAGES])
            begin
                out_next[c] = fogd_reg[DIV_STAGES][c];
            end
            else if (sat_reg[DIV_STAGES][c])
            begin
                out_next[c] = {CHAN_W{1'b1}};
            end
            else
            begin
                out_next[c] = q_reg[DIV_STAGES][c];
            end
        end
        user_next = applyd_reg[DIV_STAGES];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            thresh_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cfg_we)
            begin
                thresh_reg <= cfg_wdata;
            end
        end
    end

    // payload registers, each stage loads when it is free
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            fogx0_reg  <= fogx0_next;
            luma0_reg  <= luma0_next;
            apply0_reg <= apply0_next;
            fog0_reg   <= fog0_next;
        end
        if (rdy[1])
        begin
            d1_reg     <= d1_next;
            cl1_reg    <= cl1_next;
            apply1_reg <= apply0_reg;
            fog1_reg   <= fog0_reg;
        end
        if (rdy[2])
        begin
            rem_reg[0]    <= rem_next[0];
            q_reg[0]      <= q_next[0];
            sat_reg[0]    <= sat_next;
            dv_reg[0]     <= dv_next;
            applyd_reg[0] <= apply1_reg;
            fogd_reg[0]   <= fog1_reg;
        end
        for (int j = 1; j <= DIV_STAGES; j++)
        begin
            if (rdy[2+j])
            begin
                rem_reg[j]    <= rem_next[j];
                q_reg[j]      <= q_next[j];
                sat_reg[j]    <= sat_reg[j-1];
                dv_reg[j]     <= dv_reg[j-1];
                applyd_reg[j] <= applyd_reg[j-1];
                fogd_reg[j]   <= fogd_reg[j-1];
            end
        end
        if (rdy[NUM_STAGES-1])
        begin
            out_reg  <= out_next;
            user_reg <= user_next;
        end
    end

endmodule
